### sv/bss_pkg.sv
`timescale 1ns / 1ps

package bss_pkg;

    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 9;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(256);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(1);

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_FIND  = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_NOTFOUND  = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_FIND,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] data_out;
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] bottom_value;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
        logic                     is_full;
    } res_t;

endpackage

### sv/bss_ctrl.sv
`timescale 1ns / 1ps

module bss_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  bss_pkg::req_t               req,
    input  logic [bss_pkg::CNT_W-1:0]   cap_eff,
    output logic                        res_valid,
    input  logic                        res_ready,
    output bss_pkg::res_t               res
);
    import bss_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] bottom_reg, bottom_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [1:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     wr_en;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [CNT_W-1:0]         cnt_m2;
    logic [ADDR_W-1:0]        idx_inc;
    logic                     full;
    logic                     find_hit;
    logic                     find_last;

    assign full      = count_reg >= cap_eff;
    assign cnt_m2    = count_reg - CNT_W'(2);
    assign idx_inc   = idx_reg + ADDR_W'(1);
    assign find_hit  = rd_data_reg == key_reg;
    assign find_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= req.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_RESULT;
                    if (req.req_type == REQ_POP && count_reg > CNT_W'(1))
                    begin
                        state_next = S_POP_WAIT;
                    end
                    else if (req.req_type == REQ_FIND && count_reg != '0)
                    begin
                        state_next = S_FIND;
                    end
                end
            end
            S_POP_WAIT:
            begin
                state_next = S_RESULT;
            end
            S_FIND:
            begin
                if (find_hit || find_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        data_next   = data_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = ST_OK;
                    data_next   = '0;
                    unique case (req.req_type)
                        REQ_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                top_next   = req.value;
                                count_next = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    bottom_next = req.value;
                                end
                            end
                        end
                        REQ_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                data_next  = top_reg;
                                count_next = count_reg - CNT_W'(1);
                                // new top comes back from the store next cycle
                                if (count_reg > CNT_W'(1))
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = cnt_m2[ADDR_W-1:0];
                                end
                            end
                        end
                        REQ_FIND:
                        begin
                            key_next    = req.value;
                            idx_next    = '0;
                            status_next = ST_NOTFOUND;
                            data_next   = '1;
                            if (count_reg != '0)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                            end
                        end
                        REQ_QUERY:
                        begin
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                top_next = rd_data_reg;
            end
            S_FIND:
            begin
                // rd_data_reg holds entry idx_reg; next read goes out in parallel
                if (find_hit)
                begin
                    status_next = ST_OK;
                    data_next   = DATA_W'(idx_reg);
                end
                else if (!find_last)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc;
                    idx_next = idx_inc;
                end
            end
            S_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        req_ready        = state_reg == S_IDLE;
        res_valid        = state_reg == S_RESULT;
        res.status       = status_reg;
        res.data_out     = data_reg;
        res.top_value    = (count_reg != '0) ? top_reg : '1;
        res.bottom_value = (count_reg != '0) ? bottom_reg : '0;
        res.entry_count  = count_reg;
        res.is_empty     = count_reg == '0;
        res.is_full      = full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        bottom_reg <= bottom_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

endmodule

### sv/bounded_stack_with_search_unit.sv
`timescale 1ns / 1ps
// channel   | signals                          | transfer when
// ----------+----------------------------------+----------------------------
// request   | in_valid, in_stall, req_type,    | in_valid && !in_stall
//           | value                            |
// result    | out_valid, out_stall, status,    | out_valid && !out_stall
//           | data_out, top_value, ...         |
// config    | cfg_valid, cfg_ready, capacity   | cfg_valid && cfg_ready
//
// Push, query and a pop of the last entry go straight to the result; a pop
// that leaves entries waits in S_POP_WAIT for the new top from the store.
// A find reads one entry per cycle from the bottom up to a hit or the top.
// Reset clears the count to zero and sets capacity to 256; no clearing pass.
// The result register lets the next request in while a result is stalled.

module bounded_stack_with_search_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic signed [bss_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic signed [bss_pkg::DATA_W-1:0] data_out,
    output logic signed [bss_pkg::DATA_W-1:0] top_value,
    output logic signed [bss_pkg::DATA_W-1:0] bottom_value,
    output logic [bss_pkg::CNT_W-1:0]         entry_count,
    output logic                              is_empty,
    output logic                              is_full,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bss_pkg::CNT_W-1:0]         capacity
);
    import bss_pkg::*;

    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_eff;
    logic             req_ready;
    logic             res_valid;
    logic             res_ready;
    req_t             req;
    res_t             res;
    res_t             out_reg;
    logic             out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= capacity;
        end
    end

    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            cap_eff = CAP_MIN;
        end
        else if (cap_reg > CAP_MAX)
        begin
            cap_eff = CAP_MAX;
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign req.req_type = req_type;
    assign req.value    = value;
    assign in_stall     = !req_ready;

    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_ready (req_ready),
        .req       (req),
        .cap_eff   (cap_eff),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign data_out     = out_reg.data_out;
    assign top_value    = out_reg.top_value;
    assign bottom_value = out_reg.bottom_value;
    assign entry_count  = out_reg.entry_count;
    assign is_empty     = out_reg.is_empty;
    assign is_full      = out_reg.is_full;

endmodule

### sv/bss_checker.sv
`timescale 1ns / 1ps

module bss_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [1:0]                        status,
    input logic signed [bss_pkg::DATA_W-1:0] data_out,
    input logic signed [bss_pkg::DATA_W-1:0] top_value,
    input logic signed [bss_pkg::DATA_W-1:0] bottom_value,
    input logic [bss_pkg::CNT_W-1:0]         entry_count,
    input logic                              is_empty,
    input logic                              is_full
);
    import bss_pkg::*;

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (top_value == -1 && bottom_value == 0))
        else $error("empty stack reports wrong top or bottom");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |-> (is_full && data_out == 0))
        else $error("overflow without full stack");

    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDERFLOW) |-> (is_empty && data_out == 0))
        else $error("underflow on non-empty stack");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(data_out)))
        else $error("stalled result changed");

endmodule

bind bounded_stack_with_search_unit bss_checker u_bss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .data_out     (data_out),
    .top_value    (top_value),
    .bottom_value (bottom_value),
    .entry_count  (entry_count),
    .is_empty     (is_empty),
    .is_full      (is_full)
);
